@@ rtl/shp3_pkg.sv @@
// shared constants, types and the sharpening kernel for the 3x3 sharpen filter
package shp3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int PIX_W       = 8;
  localparam int WIDTH_CFG_W = 11;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int EW          = $clog2(MAX_WIDTH + 1);
  localparam int PW          = $clog2(MAX_WIDTH + 2);
  localparam int ACC_W       = PIX_W + 5;
  localparam int RESET_WIDTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RESET_HEIGHT = 1024;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic             is_pixel;
    logic             emit;
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             bank;
    logic             interior;
    logic             last;
  } cmd_t;

  typedef logic [8:0][PIX_W-1:0] win_t;

  function automatic logic [PIX_W-1:0] sharpen(win_t w);
    logic signed [ACC_W-1:0] acc;
    logic [PIX_W-1:0]        res;
    acc = $signed({2'b00, w[4], 3'b000}) + $signed({5'b00000, w[4]});
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        acc = acc - $signed({5'b00000, w[i]});
      end
    end
    if (acc < 0) begin
      res = '0;
    end else if (acc > $signed(ACC_W'(255))) begin
      res = '1;
    end else begin
      res = acc[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/sharpen_3x3_filter_unit.sv @@
// top level of the streaming 3x3 sharpen filter
//
//  channel | signals                                  | transfer on
//  --------+------------------------------------------+--------------------------
//  cfg     | cfg_index_i, cfg_data_i                  | cfg_valid_i & cfg_ready_o
//  in      | operation_i, pixel_i                     | in_valid_i & in_ready_o
//  out     | pixel_out_o, frame_last_o                | out_valid_o & out_ready_i
//
//  one item per cycle while in_ready_o is high; results pass queue, read and output registers
//  two line memory banks, one read and one write each per cycle, set that rate
//  reset clears positions and window; line memories start unknown, no clearing pass
//  a four-entry command queue absorbs output stalls; in_ready_o drops when it is full
//  cfg_ready_o is always high
module sharpen_3x3_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [shp3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shp3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [shp3_pkg::PIX_W-1:0]      pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [shp3_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            frame_last_o
);
  import shp3_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push_valid, push_ready, pop_valid, pop;

  assign cfg_ready_o = 1'b1;

  shp3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .pixel_i      (pixel_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  shp3_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd)
  );

  shp3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (pop_valid),
    .pop_o        (pop),
    .q_cmd_i      (pop_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ rtl/shp3_front.sv @@
// front end: frame registers, position tracking and command classification
module shp3_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [shp3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shp3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [shp3_pkg::PIX_W-1:0]      pixel_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output shp3_pkg::cmd_t                  push_cmd_o
);
  import shp3_pkg::*;

  logic [EW-1:0]          w_q, w_d;
  logic [HEIGHT_W-1:0]    h_q, h_d;
  logic [COL_W-1:0]       in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HEIGHT_W-1:0]    in_row_q, in_row_d, out_row_q, out_row_d;
  logic [PW-1:0]          pending_q, pending_d;
  logic [WIDTH_CFG_W-1:0] wv;
  logic [EW-1:0]          in_col_inc, out_col_inc;
  logic [PW-1:0]          pend_inc;
  logic                   accept, frame_in, is_drain, do_flush, do_pixel, emit_pix, do_emit;
  logic                   out_last, interior;

  assign wv         = cfg_data_i[WIDTH_CFG_W-1:0];
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    frame_in    = in_row_q >= h_q;
    is_drain    = op_e'(operation_i) == OP_DRAIN;
    do_flush    = frame_in && (pending_q != '0);
    do_pixel    = !frame_in && !is_drain;
    pend_inc    = pending_q + PW'(1);
    emit_pix    = do_pixel && (pend_inc > PW'(w_q));
    do_emit     = do_flush || emit_pix;
    in_col_inc  = EW'(in_col_q) + EW'(1);
    out_col_inc = EW'(out_col_q) + EW'(1);
    out_last    = ((HEIGHT_W+1)'(out_row_q) + (HEIGHT_W+1)'(1) == (HEIGHT_W+1)'(h_q)) &&
                  (out_col_inc == w_q);
    interior    = (out_row_q != '0) &&
                  ((HEIGHT_W+1)'(out_row_q) + (HEIGHT_W+1)'(2) <= (HEIGHT_W+1)'(h_q)) &&
                  (out_col_q != '0) &&
                  ((EW+1)'(out_col_q) + (EW+1)'(2) <= (EW+1)'(w_q));

    push_cmd_o.is_pixel = do_pixel;
    push_cmd_o.emit     = do_emit;
    push_cmd_o.pixel    = pixel_i;
    push_cmd_o.col      = do_pixel ? in_col_q : out_col_q;
    push_cmd_o.bank     = do_pixel ? in_row_q[0] : out_row_q[0];
    push_cmd_o.interior = interior;
    push_cmd_o.last     = out_last;
    push_valid_o        = accept && (do_pixel || do_flush);
  end

  always_comb begin
    w_d       = w_q;
    h_d       = h_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pending_d = pending_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH: begin
          if (wv == '0) begin
            w_d = EW'(1);
          end else if (32'(wv) > 32'(MAX_WIDTH)) begin
            w_d = EW'(MAX_WIDTH);
          end else begin
            w_d = EW'(wv);
          end
        end
        REG_IMAGE_HEIGHT: begin
          h_d = (cfg_data_i[HEIGHT_W-1:0] == '0) ? HEIGHT_W'(1) : cfg_data_i[HEIGHT_W-1:0];
        end
        default: begin
          w_d = w_q;
        end
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pending_d = '0;
    end else if (accept) begin
      if (do_pixel) begin
        if (in_col_inc >= w_q) begin
          in_col_d = '0;
          in_row_d = in_row_q + HEIGHT_W'(1);
        end else begin
          in_col_d = COL_W'(in_col_inc);
        end
        if (!do_emit) begin
          pending_d = pend_inc;
        end
      end else if (do_flush) begin
        pending_d = pending_q - PW'(1);
      end
      if (do_emit) begin
        if (out_last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          pending_d = '0;
        end else if (out_col_inc >= w_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + HEIGHT_W'(1);
        end else begin
          out_col_d = COL_W'(out_col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= EW'(RESET_WIDTH);
      h_q       <= HEIGHT_W'(RESET_HEIGHT);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pending_q <= '0;
    end else begin
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pending_q <= pending_d;
    end
  end

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PW'(w_q))
    else $error("pending count above frame width");

  a_in_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(in_col_q) < w_q)
    else $error("input column outside frame");

  a_out_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(out_col_q) < w_q)
    else $error("output column outside frame");

endmodule

@@ rtl/shp3_queue.sv @@
// command queue between front and back end
module shp3_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  shp3_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output shp3_pkg::cmd_t pop_cmd_o
);
  import shp3_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

endmodule

@@ rtl/shp3_back.sv @@
// back end: line memories, 3x3 window, kernel and output register
module shp3_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       pop_o,
  input  shp3_pkg::cmd_t             q_cmd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [shp3_pkg::PIX_W-1:0] pixel_out_o,
  output logic                       frame_last_o
);
  import shp3_pkg::*;

  logic [PIX_W-1:0] line0_mem [MAX_WIDTH];
  logic [PIX_W-1:0] line1_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd0_q, rd1_q;
  cmd_t             m_cmd_q;
  logic             m_valid_q, m_valid_d, m_fire;
  win_t             window_q, win_next;
  logic [PIX_W-1:0] top, mid, result;
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] pixel_out_q;
  logic             frame_last_q;

  assign m_fire = m_valid_q && (!m_cmd_q.emit || !out_valid_q || out_ready_i);
  assign pop_o  = q_valid_i && (!m_valid_q || m_fire);

  // bank 0 holds even rows, bank 1 odd rows
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd0_q <= line0_mem[q_cmd_i.col];
      if (q_cmd_i.is_pixel && !q_cmd_i.bank) begin
        line0_mem[q_cmd_i.col] <= q_cmd_i.pixel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd1_q <= line1_mem[q_cmd_i.col];
      if (q_cmd_i.is_pixel && q_cmd_i.bank) begin
        line1_mem[q_cmd_i.col] <= q_cmd_i.pixel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_cmd_q <= q_cmd_i;
    end
  end

  always_comb begin
    top         = m_cmd_q.bank ? rd1_q : rd0_q;
    mid         = m_cmd_q.bank ? rd0_q : rd1_q;
    win_next[0] = window_q[1];
    win_next[1] = window_q[2];
    win_next[2] = top;
    win_next[3] = window_q[4];
    win_next[4] = window_q[5];
    win_next[5] = mid;
    win_next[6] = window_q[7];
    win_next[7] = window_q[8];
    win_next[8] = m_cmd_q.pixel;
    if (!m_cmd_q.is_pixel) begin
      result = top;
    end else if (m_cmd_q.interior) begin
      result = sharpen(win_next);
    end else begin
      result = mid;
    end
    m_valid_d = pop_o ? 1'b1 : (m_fire ? 1'b0 : m_valid_q);
    if (m_fire && m_cmd_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_fire && m_cmd_q.emit) begin
      pixel_out_q  <= result;
      frame_last_q <= m_cmd_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= '0;
    end else begin
      m_valid_q   <= m_valid_d;
      out_valid_q <= out_valid_d;
      if (m_fire && m_cmd_q.is_pixel) begin
        window_q <= win_next;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_out_q;
  assign frame_last_o = frame_last_q;

endmodule

@@ tb/sharpen_3x3_filter_unit_test.sv @@
// self-checking testbench for the streaming 3x3 sharpen filter: directed table, then random frames
`timescale 1ns / 1ps

module sharpen_3x3_filter_unit_test;
  import shp3_pkg::*;

  localparam int PAD_CYCLES  = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int NUM_ROWS    = 28;
  localparam int NUM_PHASES  = 8;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_e;

  typedef enum logic [1:0] {
    STEP_IGNORED,
    STEP_TAKEN,
    STEP_EMIT
  } step_e;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } px_beat_t;

  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    idx;
    logic [15:0] data;
    op_e         op;
    logic [7:0]  pix;
    logic        fixed;
    logic        fx_res;
    logic [7:0]  fx_pix;
    logic        fx_last;
  } plan_row_t;

  typedef struct packed {
    logic [15:0] w_data;
    logic [15:0] h_data;
    flow_e       flow;
    int unsigned budget;
    logic        partial;
    logic        hold;
  } phase_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  operation_i;
  logic [PIX_W-1:0]      pixel_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  frame_last_o;

  plan_row_t plan [NUM_ROWS] = '{
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_DRAIN, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_WIDTH,  16'h0001, OP_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_HEIGHT, 16'h0001, OP_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'hA5, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_DRAIN, 8'h00, 1'b1, 1'b1, 8'hA5, 1'b1},
    '{ROW_CFG,  REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_HEIGHT, 16'h0000, OP_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
    '{ROW_CFG,  REG_IMAGE_WIDTH,  16'h0004, OP_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_HEIGHT, 16'h0003, OP_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h10, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h30, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h40, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h50, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h60, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_DRAIN, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h70, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h90, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'hA0, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_DRAIN, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_ITEM, REG_IMAGE_WIDTH,  16'h0000, OP_PIXEL, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  phase_t phases [NUM_PHASES] = '{
    '{16'hF805, 16'd4,     FLOW_FREE,        120,  1'b0, 1'b0},
    '{16'd1,    16'd9,     FLOW_SRC_GAPS,    60,   1'b0, 1'b0},
    '{16'd16,   16'd6,     FLOW_SINK_STALLS, 180,  1'b0, 1'b1},
    '{16'd3,    16'd3,     FLOW_BOTH,        80,   1'b0, 1'b0},
    '{16'd2,    16'd1,     FLOW_FREE,        40,   1'b0, 1'b0},
    '{16'd7,    16'd5,     FLOW_SRC_GAPS,    120,  1'b0, 1'b0},
    '{16'd4,    16'hFFFF,  FLOW_SINK_STALLS, 100,  1'b1, 1'b0},
    '{16'h07FF, 16'd2,     FLOW_BOTH,        190,  1'b1, 1'b0}
  };

  logic [10:0] cfg_w;
  logic [15:0] cfg_h;
  logic [7:0]  line_mem [2*MAX_WIDTH];
  logic [7:0]  tap [9];
  int unsigned in_col, in_row, out_col, out_row, owed;

  px_beat_t    pixels_due [$];
  flow_e       flow;
  bit          hold_request;
  int unsigned fail_count, in_xfers, results_seen, in_stalls;

  sharpen_3x3_filter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .frame_last_o(frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_w();
    if (cfg_w == 0) return 1;
    if (cfg_w > MAX_WIDTH) return MAX_WIDTH;
    return cfg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (cfg_h == 0) ? 1 : cfg_h;
  endfunction

  function automatic int unsigned slot(input int unsigned row, input int unsigned col);
    return (row & 1) * MAX_WIDTH + (col % MAX_WIDTH);
  endfunction

  function automatic void rewind_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    owed    = 0;
  endfunction

  // taps from never-written line locations give an unknown result
  function automatic logic [7:0] sharpen_tap();
    logic signed [12:0] acc;
    acc = $signed({5'b00000, tap[4]}) * 13'sd9;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        acc = acc - $signed({5'b00000, tap[i]});
      end
    end
    if ($isunknown(acc)) return 8'hxx;
    if (acc > 13'sd255) return 8'hFF;
    if (acc < 13'sd0) return 8'h00;
    return acc[7:0];
  endfunction

  function automatic px_beat_t emit_pixel(input logic [7:0] border, input bit use_tap);
    int unsigned w;
    int unsigned h;
    bit          interior;
    px_beat_t    b;
    w = eff_w();
    h = eff_h();
    interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
    b.pix  = (interior && use_tap) ? sharpen_tap() : border;
    b.last = (out_row + 1 == h) && (out_col + 1 == w);
    if (owed > 0) owed--;
    if (b.last) begin
      rewind_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return b;
  endfunction

  function automatic step_e step_filter(input op_e op, input logic [7:0] pix,
                                        output px_beat_t beat);
    int unsigned w;
    logic [7:0]  top;
    logic [7:0]  mid;
    logic [7:0]  border;
    beat = '0;
    w = eff_w();
    if (in_row >= eff_h()) begin
      if (owed == 0) return STEP_IGNORED;
      beat = emit_pixel(line_mem[slot(out_row, out_col)], 1'b0);
      return STEP_EMIT;
    end
    if (op == OP_DRAIN) return STEP_IGNORED;
    top    = line_mem[slot(in_row, in_col)];
    mid    = line_mem[slot(in_row ^ 1, in_col)];
    border = line_mem[slot(out_row, out_col)];
    for (int i = 0; i < 3; i++) begin
      tap[i*3]     = tap[i*3 + 1];
      tap[i*3 + 1] = tap[i*3 + 2];
    end
    tap[2] = top;
    tap[5] = mid;
    tap[8] = pix;
    line_mem[slot(in_row, in_col)] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    owed++;
    if (owed > w) begin
      beat = emit_pixel(border, 1'b1);
      return STEP_EMIT;
    end
    return STEP_TAKEN;
  endfunction

  function automatic bit idle_roll(input bit sink_side);
    bit on;
    on = sink_side ? (flow == FLOW_SINK_STALLS || flow == FLOW_BOTH)
                   : (flow == FLOW_SRC_GAPS || flow == FLOW_BOTH);
    return on && ($urandom_range(0, 99) < ((flow == FLOW_BOTH) ? 8 : 81));
  endfunction

  task automatic flag_error(input string what, input px_beat_t want, input px_beat_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected pixel %0d last %0b, got pixel %0d last %0b",
               what, want.pix, want.last, got.pix, got.last);
    end
  endtask

  task automatic settle(input bit pad);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixels_due.size() != 0) @(posedge clk_i);
    if (pad) repeat (PAD_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    settle(1'b1);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) cfg_w = data[10:0];
    else cfg_h = data;
    rewind_frame();
  endtask

  task automatic push_item(input op_e op, input logic [7:0] pix,
                           output step_e st, output px_beat_t beat);
    while (idle_roll(1'b0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    pixel_i     <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    in_xfers++;
    st = step_filter(op, pix, beat);
  endtask

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= !idle_roll(1'b1);
    end
  end

  always @(posedge clk_i) begin
    px_beat_t got;
    px_beat_t want;
    if (in_valid_i && !in_ready_o) in_stalls++;
    if (out_valid_o && out_ready_i) begin
      got = px_beat_t'{pix: pixel_out_o, last: frame_last_o};
      results_seen++;
      if (pixels_due.size() == 0) begin
        flag_error("result with nothing due", '0, got);
      end else begin
        want = pixels_due.pop_front();
        if ((!$isunknown(want.pix) && want.pix !== got.pix) || want.last !== got.last) begin
          flag_error("result mismatch", want, got);
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned taken;
    bit          paused;
    step_e       st;
    px_beat_t    beat;
    op_e         op;
    logic [7:0]  pix;
    logic [7:0]  last_pix;

    flow         = FLOW_FREE;
    hold_request = 1'b0;
    fail_count   = 0;
    in_xfers     = 0;
    results_seen = 0;
    in_stalls    = 0;
    last_pix     = 8'h00;
    cfg_w        = 11'd1024;
    cfg_h        = 16'd1024;
    foreach (line_mem[i]) line_mem[i] = 8'hxx;
    foreach (tap[i]) tap[i] = 8'h00;
    rewind_frame();

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_PIXEL;
    pixel_i     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_item(plan[i].op, plan[i].pix, st, beat);
        if (plan[i].fixed) begin
          if (plan[i].fx_res) begin
            pixels_due.push_back(px_beat_t'{pix: plan[i].fx_pix, last: plan[i].fx_last});
          end
        end else if (st == STEP_EMIT) begin
          pixels_due.push_back(beat);
        end
      end
    end

    foreach (phases[p]) begin
      flow = FLOW_FREE;
      write_reg(REG_IMAGE_WIDTH, phases[p].w_data);
      write_reg(REG_IMAGE_HEIGHT, phases[p].h_data);
      flow = phases[p].flow;
      if (phases[p].hold) hold_request = 1'b1;
      taken  = 0;
      paused = 1'b0;
      while (taken < phases[p].budget ||
             (!phases[p].partial && (in_col != 0 || in_row != 0 || owed != 0))) begin
        if (in_row >= eff_h()) begin
          op = ($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN;
        end else begin
          op = ($urandom_range(0, 15) == 0) ? OP_DRAIN : OP_PIXEL;
        end
        case ($urandom_range(0, 9))
          0: pix = 8'h00;
          1: pix = 8'hFF;
          2: pix = last_pix;
          default: pix = 8'($urandom_range(0, 255));
        endcase
        last_pix = pix;
        push_item(op, pix, st, beat);
        if (st == STEP_EMIT) pixels_due.push_back(beat);
        if (st != STEP_IGNORED) taken++;
        if (!paused && taken == phases[p].budget / 2) begin
          settle(1'b0);
          paused = 1'b1;
        end
      end
    end

    flow = FLOW_FREE;
    settle(1'b1);
    $display("covered %0d input transfers and %0d output pixels over %0d frame settings",
             in_xfers, results_seen, NUM_PHASES + 3);
    $display("input was held off by the filter in %0d cycles", in_stalls);
    if (fail_count == 0 && pixels_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sharpen_3x3_filter_unit.f @@
rtl/shp3_pkg.sv
rtl/shp3_front.sv
rtl/shp3_queue.sv
rtl/shp3_back.sv
rtl/sharpen_3x3_filter_unit.sv
tb/sharpen_3x3_filter_unit_test.sv
